// ----- hw/rtl/vttl_pkg.sv -----
package vttl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int CNT_W         = 7;

    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_ADD    = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_EXPIRE = 3'd4;

    localparam logic [1:0] MISS_NONE     = 2'd0;
    localparam logic [1:0] MISS_DISABLED = 2'd1;
    localparam logic [1:0] MISS_ABSENT   = 2'd2;
    localparam logic [1:0] MISS_VERSION  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] entry_key;
        logic [31:0] entry_version;
        logic [47:0] now_time;
        logic [47:0] age_limit;
    } t_cmd;

    typedef struct packed {
        logic             use_cached;
        logic [1:0]       miss_reason;
        logic             entry_removed;
        logic [CNT_W-1:0] expired_count;
        logic             table_full;
    } t_rsp;

    // what each cell does while the sweep token sits on it
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_ADD,
        ACT_FILL,
        ACT_REMOVE,
        ACT_LOOKUP,
        ACT_EXPIRE
    } t_act;

    // operation held steady on the bus to all cells for the whole sweep
    typedef struct packed {
        t_act        act;
        logic [63:0] key;
        logic [31:0] version;
        logic [47:0] now;
        logic [47:0] limit;
    } t_bcast;

    // partial result handed from cell to cell along with the token
    typedef struct packed {
        logic             found;
        logic             match;
        logic             claimed;
        logic [CNT_W-1:0] count;
    } t_carry;

endpackage

// ----- hw/rtl/versioned_ttl_cache_table.sv -----
// keyed cache table with per-entry version and store time
// command channel: present i_cmd with start high; it is taken at an edge where
// busy is low. busy stays high until the result has been issued.
// result channel: o_rsp is valid for exactly one cycle while o_strobe is high;
// the receiver cannot stall it, one result per command.
// config channel: i_cfg_data bit 0 is cache_enable, written when i_cfg_valid
// and o_cfg_ready are high; o_cfg_ready is always high. write only when idle.
// the table is a chain of TABLE_ENTRIES cells; a token walks it one cell per
// cycle, each cell acting on the command as the token passes.
// the strobe is registered from the token leaving the last cell; an add of a
// key not present walks the chain a second time to claim the lowest free
// entry before the result is issued. busy drops as the strobe rises, so
// the next command can be taken at the edge that ends the strobe cycle; a new
// command is not taken until the previous one's result has been issued.
// reset (synchronous, active low) empties the table, sets cache_enable to 1
// and leaves the block idle.
module versioned_ttl_cache_table
    import vttl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_strobe,
    output t_rsp o_rsp,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FILL
    } t_state;

    t_state     r_state;
    logic       r_en;
    logic       r_inj;
    logic [2:0] r_func;
    t_bcast     r_bc;

    logic       tok   [0:TABLE_ENTRIES];
    t_carry     carry [0:TABLE_ENTRIES];
    t_act       n_act;
    t_carry     last;
    t_rsp       n_rsp;
    logic       accept;
    logic       refill;
    logic       done;

    assign tok[0]   = r_inj;
    assign carry[0] = '0;
    assign last     = carry[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        vttl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (r_bc),
            .i_tok   (tok[g]),
            .i_carry (carry[g]),
            .o_tok   (tok[g+1]),
            .o_carry (carry[g+1])
        );
    end

    // disabled add, remove and lookup sweep without touching any cell
    always_comb begin
        unique case (i_cmd.func)
            FUNC_CLEAR:  n_act = ACT_CLEAR;
            FUNC_ADD:    n_act = r_en ? ACT_ADD : ACT_NONE;
            FUNC_REMOVE: n_act = r_en ? ACT_REMOVE : ACT_NONE;
            FUNC_LOOKUP: n_act = r_en ? ACT_LOOKUP : ACT_NONE;
            FUNC_EXPIRE: n_act = ACT_EXPIRE;
            default:     n_act = ACT_NONE;
        endcase
    end

    assign accept = (r_state == S_IDLE) && start;
    // key not present: second pass claims the first free cell
    assign refill = (r_state == S_SWEEP) && tok[TABLE_ENTRIES] &&
                    (r_bc.act == ACT_ADD) && !last.found;
    assign done   = (r_state != S_IDLE) && tok[TABLE_ENTRIES] && !refill;

    always_comb begin
        n_rsp = '0;
        if (r_state == S_FILL) begin
            n_rsp.table_full = !last.claimed;
        end else begin
            n_rsp.use_cached    = (r_bc.act == ACT_LOOKUP) && last.found && last.match;
            n_rsp.entry_removed = (r_bc.act == ACT_REMOVE) && last.found;
            if (r_bc.act == ACT_EXPIRE) begin
                n_rsp.expired_count = last.count;
            end
            if (r_func == FUNC_LOOKUP) begin
                priority if (r_bc.act != ACT_LOOKUP) begin
                    n_rsp.miss_reason = MISS_DISABLED;
                end else if (!last.found) begin
                    n_rsp.miss_reason = MISS_ABSENT;
                end else if (!last.match) begin
                    n_rsp.miss_reason = MISS_VERSION;
                end else begin
                    n_rsp.miss_reason = MISS_NONE;
                end
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b1;
            r_inj    <= 1'b0;
            o_strobe <= 1'b0;
            r_bc.act <= ACT_NONE;
        end else begin
            r_inj    <= accept || refill;
            o_strobe <= done;
            if (done) begin
                o_rsp <= n_rsp;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_en <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_cmd.func;
                        r_bc    <= '{act:     n_act,
                                     key:     i_cmd.entry_key,
                                     version: i_cmd.entry_version,
                                     now:     i_cmd.now_time,
                                     limit:   i_cmd.age_limit};
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (tok[TABLE_ENTRIES]) begin
                        if (refill) begin
                            r_bc.act <= ACT_FILL;
                            r_state  <= S_FILL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FILL: begin
                    if (tok[TABLE_ENTRIES]) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/vttl_cell.sv -----
module vttl_cell
    import vttl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  logic   i_tok,
    input  t_carry i_carry,
    output logic   o_tok,
    output t_carry o_carry
);

    logic        r_valid;
    logic [63:0] r_key;
    logic [31:0] r_ver;
    logic [47:0] r_stamp;
    logic        r_tok;
    t_carry      r_carry;

    logic        n_valid;
    t_carry      n_carry;
    logic        wr;
    logic        hit;
    logic        old;
    logic [47:0] age;

    assign hit = r_valid && (r_key == i_bc.key);
    assign age = i_bc.now - r_stamp;
    // negative age (clock went backwards) counts as expired
    assign old = (i_bc.now < r_stamp) || (age >= i_bc.limit);

    always_comb begin
        n_valid = r_valid;
        n_carry = i_carry;
        wr      = 1'b0;
        if (i_tok) begin
            unique case (i_bc.act)
                ACT_CLEAR: begin
                    n_valid = 1'b0;
                end
                ACT_ADD: begin
                    if (hit) begin
                        wr            = 1'b1;
                        n_carry.found = 1'b1;
                    end
                end
                ACT_FILL: begin
                    if (!r_valid && !i_carry.claimed) begin
                        wr              = 1'b1;
                        n_valid         = 1'b1;
                        n_carry.claimed = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (hit) begin
                        n_valid       = 1'b0;
                        n_carry.found = 1'b1;
                    end
                end
                ACT_LOOKUP: begin
                    if (hit) begin
                        n_carry.found = 1'b1;
                        n_carry.match = (r_ver == i_bc.version);
                    end
                end
                ACT_EXPIRE: begin
                    if (r_valid && old) begin
                        n_valid = 1'b0;
                        if (i_carry.count != CNT_MAX) begin
                            n_carry.count = i_carry.count + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (wr) begin
            r_key   <= i_bc.key;
            r_ver   <= i_bc.version;
            r_stamp <= i_bc.now;
        end
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule
